@@ sv/interpolation_template_tokenizer_core_assert.svh @@
// Assertion macros shared by the template tokenizer RTL.
// Needs a clock named clk and an active-low reset named rst_n in the including module.
`ifndef INTERPOLATION_TEMPLATE_TOKENIZER_CORE_ASSERT_SVH
`define INTERPOLATION_TEMPLATE_TOKENIZER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Checked only outside reset.
`define ITT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define ITT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ITT_ASSERT(lbl, prop, msg)
`define ITT_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ sv/itt_pkg.sv @@
// Types and constants for the interpolation template tokenizer.
// No dependencies; used by itt_parser and the top level.
package itt_pkg;

  typedef struct packed {
    logic        opcode;
    logic [20:0] char_code;
  } itt_in_t;

  typedef struct packed {
    logic [20:0] out_char;
    logic [1:0]  out_target;
    logic [2:0]  closed_slice;
    logic [1:0]  status;
    logic [15:0] fail_position;
    logic [15:0] dynamic_count;
  } itt_out_t;

  typedef enum logic [2:0] {
    ST_BASIC   = 3'd0,
    ST_DOLLAR  = 3'd1,
    ST_PAROPEN = 3'd2,
    ST_SYMBOL  = 3'd3,
    ST_EXPR    = 3'd4,
    ST_FORMAT  = 3'd5,
    ST_COLON   = 3'd6
  } itt_state_t;

  typedef enum logic [1:0] {
    TGT_NONE   = 2'd0,
    TGT_TEXT   = 2'd1,
    TGT_BODY   = 2'd2,
    TGT_FORMAT = 2'd3
  } itt_target_t;

  typedef enum logic [2:0] {
    CL_NONE   = 3'd0,
    CL_TEXT   = 3'd1,
    CL_SYMBOL = 3'd2,
    CL_EXPR   = 3'd3,
    CL_FORMAT = 3'd4
  } itt_closed_t;

  typedef enum logic [1:0] {
    STS_RUNNING = 2'd0,
    STS_OK      = 2'd1,
    STS_NODYN   = 2'd2,
    STS_FAIL    = 2'd3
  } itt_status_t;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [20:0] CH_SPACE  = 21'h20;
  localparam logic [20:0] CH_DOLLAR = 21'h24;
  localparam logic [20:0] CH_LPAREN = 21'h28;
  localparam logic [20:0] CH_RPAREN = 21'h29;
  localparam logic [20:0] CH_COLON  = 21'h3A;
  localparam logic [20:0] CH_LBRACE = 21'h7B;
  localparam logic [20:0] CH_RBRACE = 21'h7D;
  localparam logic [20:0] CH_ASCII_MAX = 21'd127;

  // Letters of the reserved symbol name "self".
  function automatic logic [20:0] self_char(input logic [1:0] idx);
    logic [20:0] ch;
    unique case (idx)
      2'd0:    ch = 21'h73;
      2'd1:    ch = 21'h65;
      2'd2:    ch = 21'h6C;
      default: ch = 21'h66;
    endcase
    return ch;
  endfunction

  function automatic logic is_letter(input logic [20:0] ch);
    return (ch >= 21'h41 && ch <= 21'h5A) || (ch >= 21'h61 && ch <= 21'h7A) ||
           (ch > CH_ASCII_MAX);
  endfunction

  function automatic logic is_alnum(input logic [20:0] ch);
    return (ch >= 21'h30 && ch <= 21'h39) || is_letter(ch);
  endfunction

endpackage

@@ sv/itt_parser.sv @@
// Tokenizer state machine: holds the parse state and computes one result per item.
// Depends on itt_pkg and interpolation_template_tokenizer_core_assert.svh.
`include "interpolation_template_tokenizer_core_assert.svh"

module itt_parser #(
  parameter longint unsigned MAX_LENGTH      = 65535,
  parameter int unsigned     MAX_BRACE_DEPTH = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  itt_pkg::itt_in_t  item,
  output itt_pkg::itt_out_t res
);

  localparam int unsigned POS_W = $clog2(MAX_LENGTH + 64'd1);
  localparam int unsigned BD_W  = $clog2(MAX_BRACE_DEPTH + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LENGTH);
  localparam logic [BD_W-1:0]  BD_MAX  = BD_W'(MAX_BRACE_DEPTH);
  localparam logic [2:0] SELF_FULL = 3'd4;
  localparam logic [2:0] SELF_NONE = 3'd5;

  itt_pkg::itt_state_t state_r, state_nxt;
  logic             paren_r, paren_nxt;
  logic [BD_W-1:0]  depth_r, depth_nxt;
  logic             text_ne_r, text_ne_nxt;
  logic             body_ne_r, body_ne_nxt;
  logic             fmt_ne_r, fmt_ne_nxt;
  logic [2:0]       self_idx_r, self_idx_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      dyn_r, dyn_nxt;
  logic             failed_r, failed_nxt;
  logic [15:0]      fail_pos_r, fail_pos_nxt;

  logic [20:0] c;
  logic is_dollar, is_lparen, is_rparen, is_colon, is_lbrace, is_rbrace, is_space;
  logic letter, alnum;
  logic len_ovf, chr_fail, new_fail, end_sym, end_bad, is_end;
  logic [BD_W-1:0] depth_dec;
  logic [15:0] dyn_inc, dyn_after, new_fail_pos;
  logic [2:0]  self_start, self_add;
  itt_pkg::itt_closed_t sym_kind;

  // Character classes and shared decode.
  always_comb begin
    c         = item.char_code;
    is_end    = (item.opcode == itt_pkg::OP_END);
    is_dollar = (c == itt_pkg::CH_DOLLAR);
    is_lparen = (c == itt_pkg::CH_LPAREN);
    is_rparen = (c == itt_pkg::CH_RPAREN);
    is_colon  = (c == itt_pkg::CH_COLON);
    is_lbrace = (c == itt_pkg::CH_LBRACE);
    is_rbrace = (c == itt_pkg::CH_RBRACE);
    is_space  = (c == itt_pkg::CH_SPACE);
    letter    = itt_pkg::is_letter(c);
    alnum     = itt_pkg::is_alnum(c);
    len_ovf   = (pos_r >= POS_MAX);
    depth_dec = (depth_r == '0) ? '0 : depth_r - BD_W'(1);
    dyn_inc   = (dyn_r == 16'hFFFF) ? dyn_r : dyn_r + 16'd1;
    sym_kind  = (self_idx_r == SELF_FULL) ? itt_pkg::CL_EXPR : itt_pkg::CL_SYMBOL;
    self_start = (c == itt_pkg::self_char(2'd0)) ? 3'd1 : SELF_NONE;
    self_add  = (self_idx_r < SELF_FULL && c == itt_pkg::self_char(self_idx_r[1:0])) ?
                self_idx_r + 3'd1 : SELF_NONE;

    unique case (state_r)
      itt_pkg::ST_DOLLAR:  chr_fail = !(is_dollar || is_lparen || is_lbrace || letter);
      itt_pkg::ST_PAROPEN: chr_fail = !(is_lbrace || letter);
      itt_pkg::ST_EXPR:    chr_fail = (is_lbrace && depth_r >= BD_MAX) ||
                                      (is_rbrace && depth_dec == '0 && !paren_r && !body_ne_r);
      itt_pkg::ST_FORMAT:  chr_fail = is_rparen && !fmt_ne_r;
      default:             chr_fail = 1'b0;
    endcase

    new_fail     = !is_end && !failed_r && (len_ovf || chr_fail);
    new_fail_pos = len_ovf ? 16'(MAX_LENGTH) : 16'(pos_r);
    // At the end marker a bare symbol still open closes first.
    end_sym      = (state_r == itt_pkg::ST_SYMBOL) && !paren_r;
    end_bad      = !end_sym && (state_r != itt_pkg::ST_BASIC);
    dyn_after    = end_sym ? dyn_inc : dyn_r;
  end

  // Next state.
  always_comb begin
    state_nxt    = state_r;
    paren_nxt    = paren_r;
    depth_nxt    = depth_r;
    text_ne_nxt  = text_ne_r;
    body_ne_nxt  = body_ne_r;
    fmt_ne_nxt   = fmt_ne_r;
    self_idx_nxt = self_idx_r;
    pos_nxt      = pos_r;
    dyn_nxt      = dyn_r;
    failed_nxt   = failed_r;
    fail_pos_nxt = fail_pos_r;
    if (is_end) begin
      state_nxt    = itt_pkg::ST_BASIC;
      paren_nxt    = 1'b0;
      depth_nxt    = '0;
      text_ne_nxt  = 1'b0;
      body_ne_nxt  = 1'b0;
      fmt_ne_nxt   = 1'b0;
      self_idx_nxt = 3'd0;
      pos_nxt      = '0;
      dyn_nxt      = 16'd0;
      failed_nxt   = 1'b0;
      fail_pos_nxt = 16'd0;
    end else if (failed_r) begin
      failed_nxt = 1'b1;
    end else if (new_fail) begin
      failed_nxt   = 1'b1;
      fail_pos_nxt = new_fail_pos;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
      unique case (state_r)
        itt_pkg::ST_BASIC: begin
          if (is_dollar) begin
            state_nxt = itt_pkg::ST_DOLLAR;
          end else begin
            text_ne_nxt = 1'b1;
          end
        end
        itt_pkg::ST_DOLLAR: begin
          if (is_dollar) begin
            state_nxt   = itt_pkg::ST_BASIC;
            text_ne_nxt = 1'b1;
          end else begin
            text_ne_nxt = 1'b0;
            if (is_lparen) begin
              paren_nxt   = 1'b1;
              state_nxt   = itt_pkg::ST_PAROPEN;
              body_ne_nxt = 1'b0;
            end else if (is_lbrace) begin
              depth_nxt   = BD_W'(1);
              state_nxt   = itt_pkg::ST_EXPR;
              body_ne_nxt = 1'b0;
            end else begin
              state_nxt    = itt_pkg::ST_SYMBOL;
              body_ne_nxt  = 1'b1;
              self_idx_nxt = self_start;
            end
          end
        end
        itt_pkg::ST_PAROPEN: begin
          if (is_lbrace) begin
            depth_nxt   = BD_W'(1);
            state_nxt   = itt_pkg::ST_EXPR;
            body_ne_nxt = 1'b0;
          end else begin
            state_nxt    = itt_pkg::ST_SYMBOL;
            body_ne_nxt  = 1'b1;
            self_idx_nxt = self_start;
          end
        end
        itt_pkg::ST_SYMBOL: begin
          if (paren_r && is_rparen) begin
            dyn_nxt   = dyn_inc;
            paren_nxt = 1'b0;
            state_nxt = itt_pkg::ST_BASIC;
          end else if (paren_r && is_colon) begin
            dyn_nxt    = dyn_inc;
            paren_nxt  = 1'b0;
            state_nxt  = itt_pkg::ST_FORMAT;
            fmt_ne_nxt = 1'b0;
          end else if (alnum) begin
            body_ne_nxt  = 1'b1;
            self_idx_nxt = self_add;
          end else begin
            dyn_nxt     = dyn_inc;
            paren_nxt   = 1'b0;
            state_nxt   = itt_pkg::ST_BASIC;
            text_ne_nxt = 1'b1;
          end
        end
        itt_pkg::ST_EXPR: begin
          if (is_lbrace) begin
            depth_nxt    = depth_r + BD_W'(1);
            body_ne_nxt  = 1'b1;
            self_idx_nxt = self_add;
          end else if (is_rbrace) begin
            depth_nxt = depth_dec;
            if (depth_dec == '0) begin
              dyn_nxt   = dyn_inc;
              paren_nxt = 1'b0;
              if (paren_r) begin
                state_nxt  = itt_pkg::ST_COLON;
                fmt_ne_nxt = 1'b0;
              end else begin
                state_nxt = itt_pkg::ST_BASIC;
              end
            end else begin
              body_ne_nxt  = 1'b1;
              self_idx_nxt = self_add;
            end
          end else begin
            body_ne_nxt  = 1'b1;
            self_idx_nxt = self_add;
          end
        end
        itt_pkg::ST_FORMAT: begin
          if (is_rparen) begin
            paren_nxt = 1'b0;
            state_nxt = itt_pkg::ST_BASIC;
          end else if (!is_space) begin
            fmt_ne_nxt = 1'b1;
          end
        end
        itt_pkg::ST_COLON: begin
          if (is_rparen) begin
            paren_nxt = 1'b0;
            state_nxt = itt_pkg::ST_BASIC;
          end else if (is_colon) begin
            state_nxt = itt_pkg::ST_FORMAT;
          end else if (!is_space) begin
            fmt_ne_nxt = 1'b1;
            state_nxt  = itt_pkg::ST_FORMAT;
          end
        end
        default: begin
          state_nxt = state_r;
        end
      endcase
    end
  end

  // Result fields.
  always_comb begin
    res = '0;
    if (is_end) begin
      if (failed_r) begin
        res.status        = itt_pkg::STS_FAIL;
        res.fail_position = fail_pos_r;
      end else if (end_bad) begin
        res.status        = itt_pkg::STS_FAIL;
        res.fail_position = 16'(pos_r);
      end else if (dyn_after == 16'd0) begin
        res.status = itt_pkg::STS_NODYN;
      end else begin
        res.status        = itt_pkg::STS_OK;
        res.dynamic_count = dyn_after;
        if (end_sym) begin
          res.closed_slice = sym_kind;
        end else if (text_ne_r) begin
          res.closed_slice = itt_pkg::CL_TEXT;
        end
      end
    end else if (failed_r) begin
      res.status        = itt_pkg::STS_FAIL;
      res.fail_position = fail_pos_r;
    end else if (new_fail) begin
      res.status        = itt_pkg::STS_FAIL;
      res.fail_position = new_fail_pos;
    end else begin
      unique case (state_r)
        itt_pkg::ST_BASIC: begin
          if (!is_dollar) begin
            res.out_char   = c;
            res.out_target = itt_pkg::TGT_TEXT;
          end
        end
        itt_pkg::ST_DOLLAR: begin
          if (is_dollar) begin
            res.out_char   = itt_pkg::CH_DOLLAR;
            res.out_target = itt_pkg::TGT_TEXT;
          end else begin
            if (text_ne_r) begin
              res.closed_slice = itt_pkg::CL_TEXT;
            end
            if (!is_lparen && !is_lbrace) begin
              res.out_char   = c;
              res.out_target = itt_pkg::TGT_BODY;
            end
          end
        end
        itt_pkg::ST_PAROPEN: begin
          if (!is_lbrace) begin
            res.out_char   = c;
            res.out_target = itt_pkg::TGT_BODY;
          end
        end
        itt_pkg::ST_SYMBOL: begin
          if (paren_r && (is_rparen || is_colon)) begin
            res.closed_slice = sym_kind;
          end else if (alnum) begin
            res.out_char   = c;
            res.out_target = itt_pkg::TGT_BODY;
          end else begin
            res.closed_slice = sym_kind;
            res.out_char     = c;
            res.out_target   = itt_pkg::TGT_TEXT;
          end
        end
        itt_pkg::ST_EXPR: begin
          if (is_rbrace && depth_dec == '0) begin
            res.closed_slice = itt_pkg::CL_EXPR;
          end else begin
            res.out_char   = c;
            res.out_target = itt_pkg::TGT_BODY;
          end
        end
        itt_pkg::ST_FORMAT: begin
          if (is_rparen) begin
            res.closed_slice = itt_pkg::CL_FORMAT;
          end else if (!is_space) begin
            res.out_char   = c;
            res.out_target = itt_pkg::TGT_FORMAT;
          end
        end
        itt_pkg::ST_COLON: begin
          if (!is_space && !is_rparen && !is_colon) begin
            res.out_char   = c;
            res.out_target = itt_pkg::TGT_FORMAT;
          end
        end
        default: begin
          res.status = itt_pkg::STS_RUNNING;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= itt_pkg::ST_BASIC;
      paren_r    <= 1'b0;
      depth_r    <= '0;
      text_ne_r  <= 1'b0;
      body_ne_r  <= 1'b0;
      fmt_ne_r   <= 1'b0;
      self_idx_r <= 3'd0;
      pos_r      <= '0;
      dyn_r      <= 16'd0;
      failed_r   <= 1'b0;
      fail_pos_r <= 16'd0;
    end else if (step) begin
      state_r    <= state_nxt;
      paren_r    <= paren_nxt;
      depth_r    <= depth_nxt;
      text_ne_r  <= text_ne_nxt;
      body_ne_r  <= body_ne_nxt;
      fmt_ne_r   <= fmt_ne_nxt;
      self_idx_r <= self_idx_nxt;
      pos_r      <= pos_nxt;
      dyn_r      <= dyn_nxt;
      failed_r   <= failed_nxt;
      fail_pos_r <= fail_pos_nxt;
    end
  end

  // A failure holds until the end marker of the template is processed.
  `ITT_ASSERT(a_fail_sticky, failed_r && !(step && is_end) |=> failed_r, "failure flag lost")
  // Every slice close clears paren mode, so plain text never sees it set.
  `ITT_ASSERT(a_basic_no_paren, state_r == itt_pkg::ST_BASIC |-> !paren_r, "paren mode in text")
  `ITT_ASSERT(a_end_resets, step && is_end |=> state_r == itt_pkg::ST_BASIC && pos_r == '0,
              "end marker did not reset")
  `ITT_ASSERT(a_pos_bound, pos_r <= POS_MAX, "character position past limit")

endmodule

@@ sv/interpolation_template_tokenizer_core.sv @@
// Top level of the interpolation template tokenizer: input register, parser, result register.
// Depends on itt_pkg, itt_parser and interpolation_template_tokenizer_core_assert.svh.
//
//   channel  | ports                           | moves per transfer
//   ---------+---------------------------------+----------------------------------------
//   input    | in_valid, in_stall, in_data     | one character or end marker
//   result   | out_valid, out_stall, out_data  | one result for each input item
//
// One item per cycle unless out_stall holds; items pass input register, then result register.
// The parser state advances when the registered item moves into the result register.
// Synchronous active-low reset returns the parse state to plain text with all counters clear.
// A stalled result holds the item behind it; input stalls only when both registers are full.
`include "interpolation_template_tokenizer_core_assert.svh"

module interpolation_template_tokenizer_core #(
  parameter longint unsigned MAX_LENGTH      = 65535,
  parameter int unsigned     MAX_BRACE_DEPTH = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  itt_pkg::itt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output itt_pkg::itt_out_t out_data
);

  logic              s1_valid_r, s1_valid_nxt;
  itt_pkg::itt_in_t  s1_data_r;
  logic              out_valid_r, out_valid_nxt;
  itt_pkg::itt_out_t out_data_r;
  itt_pkg::itt_out_t step_res;
  logic              s1_adv, in_xfer;

  always_comb begin
    s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
    in_stall = s1_valid_r && !s1_adv;
    in_xfer  = in_valid && !in_stall;
    s1_valid_nxt  = in_xfer || (s1_valid_r && !s1_adv);
    out_valid_nxt = s1_adv || (out_valid_r && out_stall);
  end

  itt_parser #(
    .MAX_LENGTH      (MAX_LENGTH),
    .MAX_BRACE_DEPTH (MAX_BRACE_DEPTH)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_adv),
    .item  (s1_data_r),
    .res   (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ITT_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid_r && !s1_valid_r, "valid after reset")
  `ITT_ASSERT(a_adv_fills, s1_adv |=> out_valid_r, "advanced item missing from result register")
  `ITT_ASSERT(a_stall_full, in_stall |-> s1_valid_r && out_valid_r, "input stalled with room")
  // A failing result never carries a character or a closed slice.
  `ITT_ASSERT(a_fail_clean, out_valid_r && out_data_r.status == itt_pkg::STS_FAIL |->
              out_data_r.out_target == itt_pkg::TGT_NONE &&
              out_data_r.closed_slice == itt_pkg::CL_NONE, "fail result carries payload")

endmodule

@@ test/interpolation_template_tokenizer_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for interpolation_template_tokenizer_core: directed rows, nesting
// limit, then random templates. Depends on itt_pkg and the core RTL only.
module interpolation_template_tokenizer_core_tb;

  localparam int MAX_LEN = 65535;
  localparam int MAX_DEPTH = 255;
  localparam int LONG_HOLD = 200;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int SELF_FULL = 4;
  localparam int SELF_NOMATCH = 5;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  itt_pkg::itt_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  itt_pkg::itt_out_t out_data;

  interpolation_template_tokenizer_core #(
    .MAX_LENGTH(MAX_LEN),
    .MAX_BRACE_DEPTH(MAX_DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("interpolation_template_tokenizer_core_tb NOT OK");
    $finish;
  end

  // Tokenizer prediction state.
  itt_pkg::itt_state_t tok_state = itt_pkg::ST_BASIC;
  bit paren_on, text_open, body_open, fmt_open, has_failed;
  int brace_lvl, self_idx, char_pos, dyn_cnt, fail_pos;

  itt_pkg::itt_out_t expected_q[$];
  int n_errors = 0;
  int n_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  bit hold_toggle = 1'b0;
  bit hold_seen = 1'b0;

  function automatic void clear_tokenizer();
    tok_state = itt_pkg::ST_BASIC;
    paren_on = 0;
    brace_lvl = 0;
    text_open = 0;
    body_open = 0;
    fmt_open = 0;
    self_idx = 0;
    char_pos = 0;
    dyn_cnt = 0;
    has_failed = 0;
    fail_pos = 0;
  endfunction

  function automatic bit letter_like(logic [20:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c > itt_pkg::CH_ASCII_MAX;
  endfunction

  function automatic void body_start(logic [20:0] c);
    body_open = 1;
    self_idx = (c == "s") ? 1 : SELF_NOMATCH;
  endfunction

  // Tracks whether the body so far spells the reserved name.
  function automatic void body_add(logic [20:0] c);
    logic [20:0] nxt;
    body_open = 1;
    case (self_idx)
      0: nxt = 21'("s");
      1: nxt = 21'("e");
      2: nxt = 21'("l");
      default: nxt = 21'("f");
    endcase
    if (self_idx < SELF_FULL && c == nxt) self_idx++;
    else self_idx = SELF_NOMATCH;
  endfunction

  function automatic void count_dyn();
    if (dyn_cnt < 65535) dyn_cnt++;
    paren_on = 0;
  endfunction

  function automatic logic [2:0] symbol_kind();
    return (self_idx == SELF_FULL) ? itt_pkg::CL_EXPR : itt_pkg::CL_SYMBOL;
  endfunction

  function automatic void fail_at(int p);
    has_failed = 1;
    fail_pos = p;
  endfunction

  task automatic tokenize_step(input itt_pkg::itt_in_t it, output itt_pkg::itt_out_t r);
    logic [20:0] c;
    c = it.char_code;
    r = '0;
    if (it.opcode == itt_pkg::OP_END) begin
      if (!has_failed) begin
        if (tok_state == itt_pkg::ST_SYMBOL && !paren_on) begin
          r.closed_slice = symbol_kind();
          count_dyn();
          tok_state = itt_pkg::ST_BASIC;
        end
        if (tok_state != itt_pkg::ST_BASIC) begin
          r.closed_slice = itt_pkg::CL_NONE;
          fail_at(char_pos);
        end else if (dyn_cnt == 0) begin
          r.status = itt_pkg::STS_NODYN;
        end else begin
          r.status = itt_pkg::STS_OK;
          if (r.closed_slice == itt_pkg::CL_NONE && text_open) r.closed_slice = itt_pkg::CL_TEXT;
          r.dynamic_count = dyn_cnt[15:0];
        end
      end
      if (has_failed) begin
        r.status = itt_pkg::STS_FAIL;
        r.fail_position = fail_pos[15:0];
      end
      clear_tokenizer();
    end else if (!has_failed && char_pos >= MAX_LEN) begin
      fail_at(MAX_LEN);
    end else if (!has_failed) begin
      case (tok_state)
        itt_pkg::ST_BASIC: begin
          if (c == itt_pkg::CH_DOLLAR) begin
            tok_state = itt_pkg::ST_DOLLAR;
          end else begin
            r.out_char = c;
            r.out_target = itt_pkg::TGT_TEXT;
            text_open = 1;
          end
        end
        itt_pkg::ST_DOLLAR: begin
          if (c == itt_pkg::CH_DOLLAR) begin
            tok_state = itt_pkg::ST_BASIC;
            r.out_char = itt_pkg::CH_DOLLAR;
            r.out_target = itt_pkg::TGT_TEXT;
            text_open = 1;
          end else if (c == itt_pkg::CH_LPAREN || c == itt_pkg::CH_LBRACE ||
                       letter_like(c)) begin
            if (c == itt_pkg::CH_LPAREN) begin
              paren_on = 1;
              tok_state = itt_pkg::ST_PAROPEN;
              body_open = 0;
            end else if (c == itt_pkg::CH_LBRACE) begin
              brace_lvl = 1;
              tok_state = itt_pkg::ST_EXPR;
              body_open = 0;
            end else begin
              tok_state = itt_pkg::ST_SYMBOL;
              body_start(c);
              r.out_char = c;
              r.out_target = itt_pkg::TGT_BODY;
            end
            // Opening a dynamic slice closes any pending static text.
            if (text_open) begin
              r.closed_slice = itt_pkg::CL_TEXT;
              text_open = 0;
            end
          end else begin
            fail_at(char_pos);
          end
        end
        itt_pkg::ST_PAROPEN: begin
          if (c == itt_pkg::CH_LBRACE) begin
            brace_lvl = 1;
            tok_state = itt_pkg::ST_EXPR;
            body_open = 0;
          end else if (letter_like(c)) begin
            tok_state = itt_pkg::ST_SYMBOL;
            body_start(c);
            r.out_char = c;
            r.out_target = itt_pkg::TGT_BODY;
          end else begin
            fail_at(char_pos);
          end
        end
        itt_pkg::ST_SYMBOL: begin
          if (c == itt_pkg::CH_RPAREN && paren_on) begin
            r.closed_slice = symbol_kind();
            count_dyn();
            tok_state = itt_pkg::ST_BASIC;
          end else if (c == itt_pkg::CH_COLON && paren_on) begin
            r.closed_slice = symbol_kind();
            count_dyn();
            tok_state = itt_pkg::ST_FORMAT;
            fmt_open = 0;
          end else if ((c >= "0" && c <= "9") || letter_like(c)) begin
            body_add(c);
            r.out_char = c;
            r.out_target = itt_pkg::TGT_BODY;
          end else begin
            r.closed_slice = symbol_kind();
            count_dyn();
            tok_state = itt_pkg::ST_BASIC;
            text_open = 1;
            r.out_char = c;
            r.out_target = itt_pkg::TGT_TEXT;
          end
        end
        itt_pkg::ST_EXPR: begin
          if (c == itt_pkg::CH_LBRACE) begin
            if (brace_lvl >= MAX_DEPTH) begin
              fail_at(char_pos);
            end else begin
              brace_lvl++;
              body_add(c);
              r.out_char = c;
              r.out_target = itt_pkg::TGT_BODY;
            end
          end else if (c == itt_pkg::CH_RBRACE) begin
            if (brace_lvl > 0) brace_lvl--;
            if (brace_lvl == 0) begin
              if (!paren_on) begin
                if (!body_open) begin
                  fail_at(char_pos);
                end else begin
                  r.closed_slice = itt_pkg::CL_EXPR;
                  count_dyn();
                  tok_state = itt_pkg::ST_BASIC;
                end
              end else begin
                r.closed_slice = itt_pkg::CL_EXPR;
                count_dyn();
                tok_state = itt_pkg::ST_COLON;
                fmt_open = 0;
              end
            end else begin
              body_add(c);
              r.out_char = c;
              r.out_target = itt_pkg::TGT_BODY;
            end
          end else begin
            body_add(c);
            r.out_char = c;
            r.out_target = itt_pkg::TGT_BODY;
          end
        end
        itt_pkg::ST_FORMAT: begin
          if (c == itt_pkg::CH_RPAREN) begin
            if (!fmt_open) begin
              fail_at(char_pos);
            end else begin
              r.closed_slice = itt_pkg::CL_FORMAT;
              paren_on = 0;
              tok_state = itt_pkg::ST_BASIC;
            end
          end else if (c != itt_pkg::CH_SPACE) begin
            fmt_open = 1;
            r.out_char = c;
            r.out_target = itt_pkg::TGT_FORMAT;
          end
        end
        default: begin
          if (c == itt_pkg::CH_RPAREN) begin
            paren_on = 0;
            tok_state = itt_pkg::ST_BASIC;
          end else if (c == itt_pkg::CH_COLON) begin
            tok_state = itt_pkg::ST_FORMAT;
          end else if (c != itt_pkg::CH_SPACE) begin
            fmt_open = 1;
            tok_state = itt_pkg::ST_FORMAT;
            r.out_char = c;
            r.out_target = itt_pkg::TGT_FORMAT;
          end
        end
      endcase
      if (has_failed) begin
        r.out_char = '0;
        r.out_target = itt_pkg::TGT_NONE;
        r.closed_slice = itt_pkg::CL_NONE;
      end else begin
        char_pos++;
      end
    end
    if (it.opcode == itt_pkg::OP_CHAR && has_failed) begin
      r.status = itt_pkg::STS_FAIL;
      r.fail_position = fail_pos[15:0];
    end
  endtask

  // Result side: random stall, or a long hold-off when the main thread asks for one.
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    itt_pkg::itt_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: unexpected result %p", out_data);
      end else begin
        want = expected_q.pop_front();
        if (out_data.out_char !== want.out_char ||
            out_data.out_target !== want.out_target ||
            out_data.closed_slice !== want.closed_slice ||
            out_data.status !== want.status ||
            out_data.fail_position !== want.fail_position ||
            out_data.dynamic_count !== want.dynamic_count) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: want %h/%0d/%0d/%0d/%0d/%0d got %h/%0d/%0d/%0d/%0d/%0d",
                     want.out_char, want.out_target, want.closed_slice, want.status,
                     want.fail_position, want.dynamic_count, out_data.out_char,
                     out_data.out_target, out_data.closed_slice, out_data.status,
                     out_data.fail_position, out_data.dynamic_count);
        end
      end
    end
  end

  // Offers one item, waits for the transfer and records what it should produce.
  task automatic send_item(input itt_pkg::itt_in_t it, input bit typed,
                           input itt_pkg::itt_out_t typed_res);
    itt_pkg::itt_out_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    tokenize_step(it, res);
    expected_q = {expected_q, (typed ? typed_res : res)};
    n_sent++;
  endtask

  task automatic send_char(input logic [20:0] c);
    itt_pkg::itt_in_t it;
    it.opcode = itt_pkg::OP_CHAR;
    it.char_code = c;
    send_item(it, 1'b0, '0);
  endtask

  task automatic send_end();
    itt_pkg::itt_in_t it;
    it.opcode = itt_pkg::OP_END;
    it.char_code = 21'($urandom_range(32'h10FFFF, 0));
    send_item(it, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  typedef struct {
    itt_pkg::itt_in_t  item;
    bit                typed;
    itt_pkg::itt_out_t res;
  } dir_row_t;

  dir_row_t         dir_rows[$];
  itt_pkg::itt_in_t tmpl_q[$];

  function automatic void add_row(logic op, logic [20:0] c, bit typed, logic [20:0] oc,
                                  itt_pkg::itt_target_t tg, itt_pkg::itt_status_t st,
                                  logic [15:0] fp);
    dir_row_t row;
    row.item.opcode = op;
    row.item.char_code = c;
    row.typed = typed;
    row.res = '0;
    row.res.out_char = oc;
    row.res.out_target = tg;
    row.res.status = st;
    row.res.fail_position = fp;
    dir_rows = {dir_rows, row};
  endfunction

  // A row whose result comes from the predictor.
  function automatic void add_free(logic op, logic [20:0] c);
    add_row(op, c, 1'b0, 21'h0, itt_pkg::TGT_NONE, itt_pkg::STS_RUNNING, 16'd0);
  endfunction

  function automatic void put(logic [20:0] c);
    itt_pkg::itt_in_t it;
    it.opcode = itt_pkg::OP_CHAR;
    it.char_code = c;
    tmpl_q = {tmpl_q, it};
  endfunction

  // Any character except the dollar, weighted toward the ones the parser reacts to.
  function automatic logic [20:0] plain_code();
    logic [20:0] c;
    case ($urandom_range(4))
      0: c = 21'($urandom_range(32'h10FFFF, 128));
      1: c = 21'($urandom_range(31, 0));
      2: begin
        case ($urandom_range(5))
          0: c = itt_pkg::CH_SPACE;
          1: c = itt_pkg::CH_RPAREN;
          2: c = itt_pkg::CH_COLON;
          3: c = itt_pkg::CH_LBRACE;
          4: c = itt_pkg::CH_RBRACE;
          default: c = itt_pkg::CH_LPAREN;
        endcase
      end
      default: c = 21'($urandom_range(126, 32));
    endcase
    if (c == itt_pkg::CH_DOLLAR) c = itt_pkg::CH_SPACE;
    return c;
  endfunction

  function automatic logic [20:0] name_code(bit first);
    logic [20:0] c;
    case ($urandom_range(first ? 2 : 3))
      0: c = 21'($urandom_range(122, 97));
      1: c = 21'($urandom_range(90, 65));
      2: c = 21'($urandom_range(32'h10FFFF, 128));
      default: c = 21'($urandom_range(57, 48));
    endcase
    return c;
  endfunction

  function automatic void put_name();
    int k;
    k = $urandom_range(9);
    if (k < 2) begin
      put(21'("s")); put(21'("e")); put(21'("l")); put(21'("f"));
    end else if (k == 2) begin
      put(21'("s")); put(21'("e")); put(21'("l"));
    end else if (k == 3) begin
      put(21'("s")); put(21'("e")); put(21'("l")); put(21'("f")); put(21'("x"));
    end else begin
      put(name_code(1'b1));
      repeat ($urandom_range(4)) put(name_code(1'b0));
    end
  endfunction

  // Expression body with balanced nested braces; the outer body is only rarely empty.
  function automatic void put_expr(int lvl);
    int n;
    logic [20:0] c;
    n = (lvl == 0 && $urandom_range(9) != 0) ? $urandom_range(4, 1) : $urandom_range(3);
    repeat (n) begin
      if (lvl < 3 && $urandom_range(4) == 0) begin
        put(itt_pkg::CH_LBRACE);
        put_expr(lvl + 1);
        put(itt_pkg::CH_RBRACE);
      end else begin
        c = plain_code();
        if (c == itt_pkg::CH_LBRACE || c == itt_pkg::CH_RBRACE) c = 21'("x");
        put(c);
      end
    end
  endfunction

  function automatic void put_fmt();
    logic [20:0] c;
    repeat ($urandom_range(4, 1)) begin
      c = plain_code();
      if (c == itt_pkg::CH_RPAREN) c = 21'("d");
      put(c);
    end
  endfunction

  function automatic void put_fragment();
    int k;
    k = $urandom_range(99);
    if (k < 28) begin
      repeat ($urandom_range(6, 1)) put(plain_code());
    end else if (k < 33) begin
      put(itt_pkg::CH_DOLLAR); put(itt_pkg::CH_DOLLAR);
    end else if (k < 48) begin
      put(itt_pkg::CH_DOLLAR); put_name();
      if ($urandom_range(3) != 0) put(plain_code());
    end else if (k < 58) begin
      put(itt_pkg::CH_DOLLAR); put(itt_pkg::CH_LPAREN);
      put_name(); put(itt_pkg::CH_RPAREN);
    end else if (k < 65) begin
      put(itt_pkg::CH_DOLLAR); put(itt_pkg::CH_LPAREN);
      put_name(); put(itt_pkg::CH_COLON);
      put_fmt(); put(itt_pkg::CH_RPAREN);
    end else if (k < 75) begin
      put(itt_pkg::CH_DOLLAR); put(itt_pkg::CH_LBRACE);
      put_expr(0); put(itt_pkg::CH_RBRACE);
    end else if (k < 83) begin
      put(itt_pkg::CH_DOLLAR); put(itt_pkg::CH_LPAREN); put(itt_pkg::CH_LBRACE);
      put_expr(0); put(itt_pkg::CH_RBRACE);
      case ($urandom_range(3))
        0: put(itt_pkg::CH_RPAREN);
        1: begin put(itt_pkg::CH_COLON); put_fmt(); put(itt_pkg::CH_RPAREN); end
        2: begin put_fmt(); put(itt_pkg::CH_RPAREN); end
        default: begin put(itt_pkg::CH_SPACE); put(itt_pkg::CH_RPAREN); end
      endcase
    end else if (k < 88) begin
      put(itt_pkg::CH_DOLLAR);
      if ($urandom_range(1) != 0) put(itt_pkg::CH_LPAREN);
      put(21'($urandom_range(32'h10FFFF, 0)));
    end else if (k < 93) begin
      repeat ($urandom_range(4, 1)) put(21'($urandom_range(32'h10FFFF, 0)));
    end else begin
      // Broken forms: empty format, unclosed slices, or a dangling dollar.
      case ($urandom_range(3))
        0: begin
          put(itt_pkg::CH_DOLLAR); put(itt_pkg::CH_LPAREN); put_name(); put(itt_pkg::CH_COLON);
          repeat ($urandom_range(2)) put(itt_pkg::CH_SPACE);
          put(itt_pkg::CH_RPAREN);
        end
        1: begin put(itt_pkg::CH_DOLLAR); put(itt_pkg::CH_LPAREN); put_name(); end
        2: begin
          put(itt_pkg::CH_DOLLAR); put(itt_pkg::CH_LPAREN); put(itt_pkg::CH_LBRACE);
          put_expr(0);
        end
        default: put(itt_pkg::CH_DOLLAR);
      endcase
    end
  endfunction

  task automatic send_template();
    itt_pkg::itt_in_t fin;
    tmpl_q.delete();
    repeat ($urandom_range(6, 1)) put_fragment();
    fin.opcode = itt_pkg::OP_END;
    fin.char_code = 21'($urandom_range(32'h10FFFF, 0));
    tmpl_q = {tmpl_q, fin};
    foreach (tmpl_q[i]) send_item(tmpl_q[i], 1'b0, '0);
  endtask

  initial begin
    int start_cnt;
    clear_tokenizer();

    add_row(itt_pkg::OP_END, 21'h10FFFF, 1, 21'h0, itt_pkg::TGT_NONE,
            itt_pkg::STS_NODYN, 16'd0);
    add_row(itt_pkg::OP_CHAR, 21'h0, 1, 21'h0, itt_pkg::TGT_TEXT,
            itt_pkg::STS_RUNNING, 16'd0);
    add_row(itt_pkg::OP_CHAR, 21'h10FFFF, 1, 21'h10FFFF, itt_pkg::TGT_TEXT,
            itt_pkg::STS_RUNNING, 16'd0);
    add_row(itt_pkg::OP_CHAR, itt_pkg::CH_DOLLAR, 1, 21'h0, itt_pkg::TGT_NONE,
            itt_pkg::STS_RUNNING, 16'd0);
    add_row(itt_pkg::OP_CHAR, itt_pkg::CH_DOLLAR, 1, itt_pkg::CH_DOLLAR, itt_pkg::TGT_TEXT,
            itt_pkg::STS_RUNNING, 16'd0);
    add_row(itt_pkg::OP_END, 21'h0, 1, 21'h0, itt_pkg::TGT_NONE,
            itt_pkg::STS_NODYN, 16'd0);
    // Bare symbol spelled as the reserved name, closed by the end marker.
    add_free(itt_pkg::OP_CHAR, itt_pkg::CH_DOLLAR);
    add_free(itt_pkg::OP_CHAR, 21'("s"));
    add_free(itt_pkg::OP_CHAR, 21'("e"));
    add_free(itt_pkg::OP_CHAR, 21'("l"));
    add_free(itt_pkg::OP_CHAR, 21'("f"));
    add_free(itt_pkg::OP_END, 21'h0);
    // Empty braced expression fails; later characters only repeat the failure.
    add_free(itt_pkg::OP_CHAR, itt_pkg::CH_DOLLAR);
    add_free(itt_pkg::OP_CHAR, itt_pkg::CH_LBRACE);
    add_row(itt_pkg::OP_CHAR, itt_pkg::CH_RBRACE, 1, 21'h0, itt_pkg::TGT_NONE,
            itt_pkg::STS_FAIL, 16'd2);
    add_row(itt_pkg::OP_CHAR, 21'("q"), 1, 21'h0, itt_pkg::TGT_NONE,
            itt_pkg::STS_FAIL, 16'd2);
    add_row(itt_pkg::OP_END, 21'h0, 1, 21'h0, itt_pkg::TGT_NONE,
            itt_pkg::STS_FAIL, 16'd2);
    // Empty expression inside parentheses is allowed, followed by a format with a space.
    add_free(itt_pkg::OP_CHAR, itt_pkg::CH_DOLLAR);
    add_free(itt_pkg::OP_CHAR, itt_pkg::CH_LPAREN);
    add_free(itt_pkg::OP_CHAR, itt_pkg::CH_LBRACE);
    add_free(itt_pkg::OP_CHAR, itt_pkg::CH_RBRACE);
    add_free(itt_pkg::OP_CHAR, itt_pkg::CH_COLON);
    add_free(itt_pkg::OP_CHAR, itt_pkg::CH_SPACE);
    add_free(itt_pkg::OP_CHAR, 21'("x"));
    add_free(itt_pkg::OP_CHAR, itt_pkg::CH_RPAREN);
    add_free(itt_pkg::OP_END, 21'h0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
    drain();

    // The deepest legal nesting is accepted; one more brace fails.
    send_char(itt_pkg::CH_DOLLAR);
    repeat (MAX_DEPTH + 1) send_char(itt_pkg::CH_LBRACE);
    send_char(itt_pkg::CH_RBRACE);
    send_end();
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0; stall_pct <= 0; hold_toggle <= ~hold_toggle; end
        1: begin idle_pct = 56; stall_pct <= 0; end
        2: begin idle_pct = 0; stall_pct <= 56; end
        default: begin idle_pct = 18; stall_pct <= 18; end
      endcase
      start_cnt = n_sent;
      while (n_sent - start_cnt < ITEMS_PER_PHASE) send_template();
      drain();
    end

    repeat (8) @(posedge clk);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("interpolation_template_tokenizer_core_tb OK");
    end else begin
      $display("interpolation_template_tokenizer_core_tb NOT OK");
    end
    $finish;
  end

endmodule
